>>> rtl/sss_pkg.sv
// Package for the stereo side shaper: widths, fixed-point constants,
// register indexes and the context word carried through the divider stages.
// No dependencies.
package sss_pkg;

  // Sample and knob formats.
  localparam int SAMPLE_W   = 24;
  localparam int FRAC_W     = 22;
  localparam int KNOB_W     = 17;
  localparam int IDX_W      = 3;

  // Divider geometry: one quotient bit per stage.
  localparam int DIV_STEPS  = 22;
  localparam int DIV_W      = 40;
  localparam int QUOT_W     = 23;

  localparam logic [QUOT_W-1:0] SAMPLE_ONE = 23'd4194304;
  localparam logic [KNOB_W-1:0] KNOB_ONE   = 17'd65536;
  localparam logic [KNOB_W-1:0] KNOB_HALF  = 17'd32768;
  // 1.0 in knob units times 1.0 in sample units (2^38).
  localparam logic [DIV_W-1:0]  PROD_ONE   = 40'd274877906944;

  localparam logic signed [24:0] CLIP_POS = 25'sd4194304;
  localparam logic signed [24:0] CLIP_NEG = -25'sd4194304;
  localparam logic signed [25:0] SAT_HI   = 26'sd8388607;
  localparam logic signed [25:0] SAT_LO   = -26'sd8388608;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_ZONE_A = 3'd1,
    CFG_ZONE_B = 3'd2,
    CFG_INFL   = 3'd3,
    CFG_LOWER  = 3'd4,
    CFG_UPPER  = 3'd5
  } cfg_idx_e;

  // Everything a word needs after the segment has been chosen.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] side;
    logic                neg;
    logic                shaped;
    logic [SAMPLE_W-1:0] y0;
    logic [SAMPLE_W-1:0] ylen;
    logic                comp;
    logic [KNOB_W-1:0]   tens;
    logic                dz;
  } ctx_t;

endpackage

>>> rtl/sss_if.sv
// Channel interfaces of the stereo side shaper: sample input, sample output
// and the configuration write channel. Depends on sss_pkg.
interface sss_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sss_pkg::SAMPLE_W-1:0]   left_sample;
  logic signed [sss_pkg::SAMPLE_W-1:0]   right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface sss_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sss_pkg::SAMPLE_W-1:0]   left_out;
  logic signed [sss_pkg::SAMPLE_W-1:0]   right_out;
  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

interface sss_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sss_pkg::IDX_W-1:0]          index;
  logic [sss_pkg::KNOB_W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/stereo_side_shaper.sv
// Stereo side shaper top level: mid/side split, zone test, two-segment
// curve and recombination. Depends on sss_pkg, sss_if and sss_div_pipe.
//
// One stereo word is taken every clock cycle while the output is not held
// off. Each word passes through the two 22-stage restoring dividers
// (segment position, then the rational curve) plus nine stages of
// multiply, select and saturate. Each stage moves on whenever it is
// empty or the one after it moves, so a held output only stops words as
// the pipeline fills up behind it. Configuration writes are taken at
// once and should only be made while no word is in flight.
module stereo_side_shaper (
  input  logic    clk_i,
  input  logic    rst_ni,
  sss_in_if.sink  smp_in,
  sss_out_if.source smp_out,
  sss_cfg_if.sink cfg
);

  // Configuration registers.
  logic                        mode_q;
  logic [sss_pkg::KNOB_W-1:0]  knob_q [5];
  logic [sss_pkg::KNOB_W-1:0]  wr_sat;

  assign cfg.ready = 1'b1;
  assign wr_sat = (cfg.data > sss_pkg::KNOB_ONE) ? sss_pkg::KNOB_ONE : cfg.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      knob_q[0] <= '0;
      knob_q[1] <= '0;
      knob_q[2] <= sss_pkg::KNOB_HALF;
      knob_q[3] <= sss_pkg::KNOB_HALF;
      knob_q[4] <= sss_pkg::KNOB_HALF;
    end else if (cfg.valid) begin
      unique case (sss_pkg::cfg_idx_e'(cfg.index))
        sss_pkg::CFG_MODE:   mode_q    <= cfg.data[0];
        sss_pkg::CFG_ZONE_A: knob_q[0] <= wr_sat;
        sss_pkg::CFG_ZONE_B: knob_q[1] <= wr_sat;
        sss_pkg::CFG_INFL:   knob_q[2] <= wr_sat;
        sss_pkg::CFG_LOWER:  knob_q[3] <= wr_sat;
        sss_pkg::CFG_UPPER:  knob_q[4] <= wr_sat;
        default: ;
      endcase
    end
  end

  // Stage valids and advance chain.
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, vo_q;
  logic adv0, adv1, adv2, adv3, adv4, adv5, adv6, adv7, advo;
  logic d1_in_ready, d1_out_valid, d2_in_ready, d2_out_valid;

  assign advo = !vo_q || smp_out.ready;
  assign adv7 = !v7_q || advo;
  assign adv6 = !v6_q || adv7;
  assign adv5 = !v5_q || d2_in_ready;
  assign adv4 = !v4_q || adv5;
  assign adv3 = !v3_q || d1_in_ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign adv0 = !v0_q || adv1;
  assign smp_in.ready = adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= smp_in.valid;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= d1_out_valid;
      if (adv5) v5_q <= v4_q;
      if (adv6) v6_q <= d2_out_valid;
      if (adv7) v7_q <= v6_q;
      if (advo) vo_q <= v7_q;
    end
  end

  // Stage 0: input register.
  logic [23:0] l0_q, r0_q;
  always_ff @(posedge clk_i) begin
    if (adv0 && smp_in.valid) begin
      l0_q <= smp_in.left_sample;
      r0_q <= smp_in.right_sample;
    end
  end

  // Stage 1: mid and side with rounding toward zero, magnitude, zone.
  logic [24:0] sum1, dif1, midr, sider;
  logic [23:0] mid1, side1, mneg1, s1, e1;
  logic [22:0] ks, ke, mag1;
  logic [21:0] rad1;
  logic        in1;

  assign sum1  = {l0_q[23], l0_q} + {r0_q[23], r0_q};
  assign dif1  = {l0_q[23], l0_q} - {r0_q[23], r0_q};
  assign midr  = sum1 + {24'd0, sum1[24]};
  assign sider = dif1 + {24'd0, dif1[24]};
  assign mid1  = midr[24:1];
  assign side1 = sider[24:1];
  assign mneg1 = -side1;
  assign mag1  = side1[23] ? mneg1[22:0] : side1[22:0];
  assign ks    = {knob_q[0], 6'd0};
  assign ke    = {knob_q[1], 6'd0};
  assign rad1  = {knob_q[1], 5'd0};

  // Zone bounds; centre mode clips the zone into the unit range.
  always_comb begin
    if (!mode_q) begin
      s1 = {1'b0, ks};
      e1 = {1'b0, ke};
    end else if (ks < {1'b0, rad1}) begin
      s1 = '0;
      e1 = {ks, 1'b0};
    end else if (({1'b0, ks} + {2'b0, rad1}) > {1'b0, sss_pkg::SAMPLE_ONE}) begin
      s1 = {ks, 1'b0} - {1'b0, sss_pkg::SAMPLE_ONE};
      e1 = {1'b0, sss_pkg::SAMPLE_ONE};
    end else begin
      s1 = {1'b0, ks} - {2'b0, rad1};
      e1 = {1'b0, ks} + {2'b0, rad1};
    end
  end
  assign in1 = ({1'b0, mag1} > s1) && ({1'b0, mag1} < e1);

  logic [23:0] mid1_q, side1_q, s1_q, e1_q;
  logic [22:0] mag1_q;
  logic        neg1_q, in1_q;
  always_ff @(posedge clk_i) begin
    if (adv1 && v0_q) begin
      mid1_q  <= mid1;
      side1_q <= side1;
      neg1_q  <= side1[23];
      mag1_q  <= mag1;
      s1_q    <= s1;
      e1_q    <= e1;
      in1_q   <= in1;
    end
  end

  // Stage 2: inflection point in x and y.
  logic [23:0] d2, ix2, iy2;
  logic [40:0] px2, py2;
  assign d2  = e1_q - s1_q;
  assign px2 = d2 * knob_q[2];
  assign py2 = d2 * (sss_pkg::KNOB_ONE - knob_q[2]);
  assign ix2 = s1_q + px2[39:16];
  assign iy2 = s1_q + py2[39:16];

  logic [23:0] mid2_q, side2_q, s2_q, e2_q, ix2_q, iy2_q;
  logic [22:0] mag2_q;
  logic        neg2_q, in2_q;
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      mid2_q  <= mid1_q;
      side2_q <= side1_q;
      neg2_q  <= neg1_q;
      mag2_q  <= mag1_q;
      s2_q    <= s1_q;
      e2_q    <= e1_q;
      in2_q   <= in1_q;
      ix2_q   <= ix2;
      iy2_q   <= iy2;
    end
  end

  // Stage 3: pick the segment and its tension.
  logic [23:0]  a3, x03, xlen3;
  logic [16:0]  knob3, kd3;
  logic         lower3, upper3, comp3;
  sss_pkg::ctx_t ctx3;

  assign a3     = {1'b0, mag2_q};
  assign lower3 = a3 < ix2_q;
  assign upper3 = a3 > ix2_q;
  assign x03    = lower3 ? s2_q : ix2_q;
  assign xlen3  = lower3 ? (ix2_q - s2_q) : (e2_q - ix2_q);
  assign knob3  = lower3 ? knob_q[3] : knob_q[4];
  assign comp3  = knob3 > sss_pkg::KNOB_HALF;
  assign kd3    = comp3 ? (knob3 - sss_pkg::KNOB_HALF) : (sss_pkg::KNOB_HALF - knob3);

  always_comb begin
    ctx3.mid    = mid2_q;
    ctx3.side   = side2_q;
    ctx3.neg    = neg2_q;
    ctx3.shaped = in2_q && (lower3 || upper3);
    ctx3.y0     = lower3 ? s2_q : iy2_q;
    ctx3.ylen   = lower3 ? (iy2_q - s2_q) : (e2_q - iy2_q);
    ctx3.comp   = comp3;
    ctx3.tens   = {kd3[15:0], 1'b0};
    ctx3.dz     = 1'b0;
  end

  logic [23:0]   num3_q, xlen3_q;
  sss_pkg::ctx_t ctx3_q;
  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      num3_q  <= a3 - x03;
      xlen3_q <= xlen3;
      ctx3_q  <= ctx3;
    end
  end

  // Segment position n = (|side| - x0) / xlen in sample units.
  logic [sss_pkg::QUOT_W-1:0] quo1;
  sss_pkg::ctx_t              ctx1o;

  sss_div_pipe u_div_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (d1_in_ready),
    .rem_i       ({16'd0, num3_q}),
    .den_i       ({16'd0, xlen3_q}),
    .q_i         (1'b0),
    .ctx_i       (ctx3_q),
    .out_valid_o (d1_out_valid),
    .out_ready_i (adv4),
    .quot_o      (quo1),
    .ctx_o       (ctx1o)
  );

  // Stage 4: curve numerator and tension product.
  logic [22:0]   nc4, nn4;
  logic [39:0]   pa4, pt4;
  assign nc4 = (quo1 > sss_pkg::SAMPLE_ONE) ? sss_pkg::SAMPLE_ONE : quo1;
  assign nn4 = ctx1o.comp ? nc4 : (sss_pkg::SAMPLE_ONE - nc4);
  assign pa4 = nn4 * (sss_pkg::KNOB_ONE - ctx1o.tens);
  assign pt4 = nn4 * ctx1o.tens;

  logic [39:0]   pa4_q, pt4_q;
  sss_pkg::ctx_t ctx4_q;
  always_ff @(posedge clk_i) begin
    if (adv4 && d1_out_valid) begin
      pa4_q  <= pa4;
      pt4_q  <= pt4;
      ctx4_q <= ctx1o;
    end
  end

  // Stage 5: curve denominator and integer quotient bit.
  logic [39:0]   dd5;
  logic          ge5;
  sss_pkg::ctx_t ctx5;
  assign dd5 = sss_pkg::PROD_ONE - pt4_q;
  assign ge5 = pa4_q >= dd5;
  always_comb begin
    ctx5    = ctx4_q;
    ctx5.dz = (dd5 == '0);
  end

  logic [39:0]   r5_q, d5_q;
  logic          q5_q;
  sss_pkg::ctx_t ctx5_q;
  always_ff @(posedge clk_i) begin
    if (adv5 && v4_q) begin
      r5_q   <= ge5 ? (pa4_q - dd5) : pa4_q;
      d5_q   <= dd5;
      q5_q   <= ge5;
      ctx5_q <= ctx5;
    end
  end

  // Rational curve quotient.
  logic [sss_pkg::QUOT_W-1:0] quo2;
  sss_pkg::ctx_t              ctx2o;

  sss_div_pipe u_div_curve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_ready_o  (d2_in_ready),
    .rem_i       (r5_q),
    .den_i       (d5_q),
    .q_i         (q5_q),
    .ctx_i       (ctx5_q),
    .out_valid_o (d2_out_valid),
    .out_ready_i (adv6),
    .quot_o      (quo2),
    .ctx_o       (ctx2o)
  );

  // Stage 6: curve value, mirrored for an expanding segment.
  logic [22:0] c6, g6;
  assign c6 = ctx2o.dz ? sss_pkg::SAMPLE_ONE : quo2;
  assign g6 = ctx2o.comp ? c6 : (sss_pkg::SAMPLE_ONE - c6);

  logic [22:0]   g6_q;
  sss_pkg::ctx_t ctx6_q;
  always_ff @(posedge clk_i) begin
    if (adv6 && d2_out_valid) begin
      g6_q   <= g6;
      ctx6_q <= ctx2o;
    end
  end

  // Stage 7: scale into the output segment and restore the sign.
  logic [46:0] pr7;
  logic [23:0] o7;
  logic [24:0] sd7;
  assign pr7 = g6_q * ctx6_q.ylen;
  assign o7  = ctx6_q.y0 + pr7[45:22];
  always_comb begin
    if (!ctx6_q.shaped) begin
      sd7 = {ctx6_q.side[23], ctx6_q.side};
    end else if (ctx6_q.neg) begin
      sd7 = -{1'b0, o7};
    end else begin
      sd7 = {1'b0, o7};
    end
  end

  logic [23:0] mid7_q;
  logic [24:0] sd7_q;
  always_ff @(posedge clk_i) begin
    if (adv7 && v6_q) begin
      mid7_q <= ctx6_q.mid;
      sd7_q  <= sd7;
    end
  end

  // Output stage: clip mid and side, recombine and saturate.
  logic signed [24:0] mx, sx, mc, sc;
  logic signed [25:0] ls, rs;
  logic [23:0]        lo, ro;
  assign mx = $signed({mid7_q[23], mid7_q});
  assign sx = $signed(sd7_q);
  assign mc = (mx > sss_pkg::CLIP_POS) ? sss_pkg::CLIP_POS :
              (mx < sss_pkg::CLIP_NEG) ? sss_pkg::CLIP_NEG : mx;
  assign sc = (sx > sss_pkg::CLIP_POS) ? sss_pkg::CLIP_POS :
              (sx < sss_pkg::CLIP_NEG) ? sss_pkg::CLIP_NEG : sx;
  assign ls = {mc[24], mc} + {sc[24], sc};
  assign rs = {mc[24], mc} - {sc[24], sc};
  assign lo = (ls > sss_pkg::SAT_HI) ? 24'h7fffff :
              (ls < sss_pkg::SAT_LO) ? 24'h800000 : ls[23:0];
  assign ro = (rs > sss_pkg::SAT_HI) ? 24'h7fffff :
              (rs < sss_pkg::SAT_LO) ? 24'h800000 : rs[23:0];

  logic [23:0] lo_q, ro_q;
  always_ff @(posedge clk_i) begin
    if (advo && v7_q) begin
      lo_q <= lo;
      ro_q <= ro;
    end
  end

  assign smp_out.valid     = vo_q;
  assign smp_out.left_out  = lo_q;
  assign smp_out.right_out = ro_q;

endmodule

>>> rtl/sss_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a context
// word riding alongside. Depends on sss_pkg.
module sss_div_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sss_pkg::DIV_W-1:0]   rem_i,
  input  logic [sss_pkg::DIV_W-1:0]   den_i,
  input  logic                        q_i,
  input  sss_pkg::ctx_t               ctx_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sss_pkg::QUOT_W-1:0]  quot_o,
  output sss_pkg::ctx_t               ctx_o
);

  logic                        v_q   [sss_pkg::DIV_STEPS];
  logic [sss_pkg::DIV_W-1:0]   r_q   [sss_pkg::DIV_STEPS];
  logic [sss_pkg::DIV_W-1:0]   den_q [sss_pkg::DIV_STEPS];
  logic [sss_pkg::QUOT_W-1:0]  quo_q [sss_pkg::DIV_STEPS];
  sss_pkg::ctx_t               ctx_q [sss_pkg::DIV_STEPS];
  logic                        adv   [sss_pkg::DIV_STEPS+1];

  // A stage moves on when it is empty or the next one moves.
  assign adv[sss_pkg::DIV_STEPS] = out_ready_i;
  assign in_ready_o = adv[0];

  for (genvar i = 0; i < sss_pkg::DIV_STEPS; i++) begin : g_step
    logic                        vin;
    logic [sss_pkg::DIV_W-1:0]   rin;
    logic [sss_pkg::DIV_W-1:0]   din;
    logic [sss_pkg::QUOT_W-1:0]  qin;
    sss_pkg::ctx_t               cin;
    logic [sss_pkg::DIV_W:0]     shl;
    logic [sss_pkg::DIV_W:0]     dif;
    logic                        ge;

    if (i == 0) begin : g_first
      assign vin = in_valid_i;
      assign rin = rem_i;
      assign din = den_i;
      assign qin = {{(sss_pkg::QUOT_W-1){1'b0}}, q_i};
      assign cin = ctx_i;
    end else begin : g_next
      assign vin = v_q[i-1];
      assign rin = r_q[i-1];
      assign din = den_q[i-1];
      assign qin = quo_q[i-1];
      assign cin = ctx_q[i-1];
    end

    // One restoring step: shift the remainder, subtract if it fits.
    assign shl = {rin, 1'b0};
    assign dif = shl - {1'b0, din};
    assign ge  = shl >= {1'b0, din};
    assign adv[i] = !v_q[i] || adv[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (adv[i]) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[i] && vin) begin
        r_q[i]   <= ge ? dif[sss_pkg::DIV_W-1:0] : shl[sss_pkg::DIV_W-1:0];
        den_q[i] <= din;
        quo_q[i] <= {qin[sss_pkg::QUOT_W-2:0], ge};
        ctx_q[i] <= cin;
      end
    end
  end

  assign out_valid_o = v_q[sss_pkg::DIV_STEPS-1];
  assign quot_o      = quo_q[sss_pkg::DIV_STEPS-1];
  assign ctx_o       = ctx_q[sss_pkg::DIV_STEPS-1];

endmodule

>>> rtl/sss_checker.sv
// Port-level checker for the stereo side shaper and its bind statement.
// Depends on stereo_side_shaper and its interfaces.
module sss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] left_out_i,
  input logic [23:0] right_out_i
);

  // A held result word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word withdrawn while stalled");

  // A held result word keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(left_out_i) && $stable(right_out_i))
    else $error("result word changed while stalled");

  // With the output draining, nothing in the pipeline can hold off input.
  a_no_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input held off while output drains");

  // Nothing is offered straight out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result word offered after reset");

endmodule

bind stereo_side_shaper sss_checker u_sss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (smp_in.ready),
  .out_valid_i (smp_out.valid),
  .out_ready_i (smp_out.ready),
  .left_out_i  (smp_out.left_out),
  .right_out_i (smp_out.right_out)
);

>>> tb/sv/stereo_side_shaper_tb.sv
// Testbench for the stereo side shaper: drives stereo words and register
// writes, predicts each processed pair and compares it with the block output.
// Depends on sss_pkg, sss_if and the stereo_side_shaper RTL.
`timescale 1ns / 100ps

module stereo_side_shaper_tb;

  typedef struct {
    logic signed [sss_pkg::SAMPLE_W-1:0] left;
    logic signed [sss_pkg::SAMPLE_W-1:0] right;
  } pair_t;

  localparam longint ONE_S = 64'sd4194304;
  localparam longint KONE  = 64'sd65536;
  localparam int LATENCY   = 53;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sss_in_if  smp_in ();
  sss_out_if smp_out ();
  sss_cfg_if cfg ();

  stereo_side_shaper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_in (smp_in.sink),
    .smp_out(smp_out.source),
    .cfg    (cfg.sink)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the register file.
  logic   shadow_mode;
  longint shadow_knob [5];

  pair_t  pending_words [$];
  pair_t  expected_pairs [$];
  int     error_count;
  int     cycle_count;
  bit     stimulus_done;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Rational curve n(1-t)/(1-t n), floor, in sample units.
  function automatic longint bend(input longint n, input longint t);
    longint unsigned num, den;
    num = longint'(n) * longint'(KONE - t);
    den = KONE * ONE_S - t * n;
    if (den == 0) return ONE_S;
    // num < 2^39 and den <= 2^38, so num * 2^22 fits in 64 bits unsigned.
    return longint'((num << 22) / den);
  endfunction

  function automatic longint knob_to_samples(input longint k);
    return (k * ONE_S) / KONE;
  endfunction

  function automatic longint map_segment(input longint a, input longint x0,
                                         input longint xlen, input longint y0,
                                         input longint ylen, input longint knob);
    longint t, n, g;
    bit     compress;
    compress = knob > KONE / 2;
    t = compress ? (knob - KONE / 2) * 2 : (KONE / 2 - knob) * 2;
    if (t > KONE) t = KONE;
    n = ((a - x0) * ONE_S) / xlen;
    if (n > ONE_S) n = ONE_S;
    g = compress ? bend(n, t) : ONE_S - bend(ONE_S - n, t);
    return y0 + (g * ylen) / ONE_S;
  endfunction

  function automatic longint saturate(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Predicts the processed pair for one stereo word.
  function automatic pair_t shape_pair(input pair_t w);
    longint l, r, mid, side, s, e, c, rad, a, d, ix, iy, o;
    pair_t  res;
    l = w.left;
    r = w.right;
    mid  = (l + r) / 2;
    side = (l - r) / 2;
    if (!shadow_mode) begin
      s = knob_to_samples(shadow_knob[0]);
      e = knob_to_samples(shadow_knob[1]);
    end else begin
      c = knob_to_samples(shadow_knob[0]);
      rad = knob_to_samples(shadow_knob[1]) / 2;
      s = c - rad;
      e = c + rad;
      if (s < 0) begin
        s = 0;
        e = 2 * c;
      end else if (e > ONE_S) begin
        s = 2 * c - ONE_S;
        e = ONE_S;
      end
    end
    a = side < 0 ? -side : side;
    if (a > s && a < e) begin
      o = a;
      d = e - s;
      ix = s + (d * shadow_knob[2]) / KONE;
      iy = s + (d * (KONE - shadow_knob[2])) / KONE;
      if (a < ix) o = map_segment(a, s, ix - s, s, iy - s, shadow_knob[3]);
      else if (a > ix) o = map_segment(a, ix, e - ix, iy, e - iy, shadow_knob[4]);
      side = side < 0 ? -o : o;
    end
    if (mid > ONE_S) mid = ONE_S;
    else if (mid < -ONE_S) mid = -ONE_S;
    if (side > ONE_S) side = ONE_S;
    else if (side < -ONE_S) side = -ONE_S;
    res.left  = sss_pkg::SAMPLE_W'(saturate(mid + side));
    res.right = sss_pkg::SAMPLE_W'(saturate(mid - side));
    return res;
  endfunction

  // Register write through the configuration channel, mirrored in the shadow.
  task automatic write_register(input sss_pkg::cfg_idx_e idx,
                                input logic [sss_pkg::KNOB_W-1:0] val);
    longint v;
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    v = val;
    if (idx == sss_pkg::CFG_MODE) shadow_mode = val[0];
    else shadow_knob[idx - 1] = v > KONE ? KONE : v;
  endtask

  // Waits until every expected word has come and the pipeline has drained.
  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_pairs.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [sss_pkg::KNOB_W-1:0] random_knob();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return sss_pkg::KNOB_ONE;
      2: return 17'($urandom_range(65537, 131071));
      3: return sss_pkg::KNOB_HALF;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic pair_t random_word();
    pair_t w;
    logic signed [sss_pkg::SAMPLE_W-1:0] m, sd;
    case ($urandom_range(0, 3))
      0: begin
        w.left  = sss_pkg::SAMPLE_W'($urandom);
        w.right = sss_pkg::SAMPLE_W'($urandom);
      end
      default: begin
        // Mostly in-range mid with a side spread over the zone range.
        m  = $signed(24'($urandom_range(0, 8388607))) - 24'sd4194304;
        sd = 24'($urandom_range(0, 4194303));
        if ($urandom_range(0, 1)) sd = -sd;
        w.left  = (m >>> 1) + sd;
        w.right = (m >>> 1) - sd;
      end
    endcase
    return w;
  endfunction

  task automatic queue_word(input logic signed [sss_pkg::SAMPLE_W-1:0] l,
                            input logic signed [sss_pkg::SAMPLE_W-1:0] r);
    pair_t w;
    w.left = l;
    w.right = r;
    pending_words.push_back(w);
  endtask

  // Stimulus: directed words, then random phases under changing settings.
  initial begin
    smp_in.valid = 1'b0;
    smp_in.left_sample = '0;
    smp_in.right_sample = '0;
    smp_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = sss_pkg::CFG_MODE;
    cfg.data = '0;
    shadow_mode = 1'b0;
    shadow_knob[0] = 0;
    shadow_knob[1] = 0;
    shadow_knob[2] = 32768;
    shadow_knob[3] = 32768;
    shadow_knob[4] = 32768;
    stimulus_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: the zone is empty, so side passes unchanged.
    queue_word(24'sh7fffff, 24'sh800000);
    queue_word(24'sh800000, 24'sh7fffff);
    queue_word(24'sh7fffff, 24'sh7fffff);
    queue_word(24'sh800000, 24'sh800000);
    wait_idle();

    // A zone over the whole range with compressing and expanding segments.
    write_register(sss_pkg::CFG_ZONE_A, 17'd0);
    write_register(sss_pkg::CFG_ZONE_B, sss_pkg::KNOB_ONE);
    write_register(sss_pkg::CFG_INFL, 17'd16384);
    write_register(sss_pkg::CFG_LOWER, sss_pkg::KNOB_ONE);
    write_register(sss_pkg::CFG_UPPER, 17'd0);
    queue_word(24'sd0, 24'sd0);
    queue_word(24'sd1048576, -24'sd1048576);   // side at the inflection x
    queue_word(24'sd2, -24'sd2);
    queue_word(-24'sd4194303, 24'sd4194303);
    queue_word(24'sd3000000, 24'sd1000);
    queue_word(24'sh7fffff, 24'sh800000);
    queue_word(-24'sd3, 24'sd3);
    wait_idle();

    // Centre mode near both edges, and knobs above 1.0.
    write_register(sss_pkg::CFG_MODE, 17'd1);
    write_register(sss_pkg::CFG_ZONE_A, 17'd8192);
    write_register(sss_pkg::CFG_ZONE_B, 17'h1ffff);
    write_register(sss_pkg::CFG_LOWER, 17'd40000);
    write_register(sss_pkg::CFG_UPPER, 17'd20000);
    queue_word(24'sd600000, -24'sd600000);
    queue_word(-24'sd200000, 24'sd200000);
    queue_word(24'sd300000, 24'sd100000);
    wait_idle();
    write_register(sss_pkg::CFG_ZONE_A, 17'd60000);
    queue_word(24'sd4000000, -24'sd4000000);
    queue_word(-24'sd3900000, 24'sd3700000);
    queue_word(24'sd4100000, -24'sd3500000);
    wait_idle();

    // Random phases.
    for (int phase = 0; phase < 14; phase++) begin
      write_register(sss_pkg::CFG_MODE, 17'($urandom_range(0, 1)));
      write_register(sss_pkg::CFG_ZONE_A, random_knob());
      write_register(sss_pkg::CFG_ZONE_B, random_knob());
      write_register(sss_pkg::CFG_INFL, random_knob());
      write_register(sss_pkg::CFG_LOWER, random_knob());
      write_register(sss_pkg::CFG_UPPER, random_knob());
      for (int i = 0; i < 100; i++) pending_words.push_back(random_word());
      wait_idle();
    end
    stimulus_done = 1'b1;
  end

  // Driver: presents queued words after a random gap.
  int send_gap;
  initial send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (smp_in.valid && smp_in.ready) begin
        expected_pairs.push_back(shape_pair(pending_words.pop_front()));
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (send_gap > 0) begin
        send_gap--;
        smp_in.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        smp_in.valid <= 1'b1;
        smp_in.left_sample <= pending_words[0].left;
        smp_in.right_sample <= pending_words[0].right;
      end else begin
        smp_in.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure and comparison with the oldest prediction.
  int hold_off;
  initial hold_off = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (smp_out.valid && smp_out.ready) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("output word with no expectation waiting");
        end else begin
          pair_t want;
          want = expected_pairs.pop_front();
          if (smp_out.left_out !== want.left)
            report_mismatch($sformatf("left_out %0d, expected %0d",
                                      smp_out.left_out, want.left));
          if (smp_out.right_out !== want.right)
            report_mismatch($sformatf("right_out %0d, expected %0d",
                                      smp_out.right_out, want.right));
        end
        hold_off = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
      end
      if (hold_off > 0) begin
        hold_off--;
        smp_out.ready <= 1'b0;
      end else begin
        smp_out.ready <= 1'b1;
      end
    end
  end

  // End of run and timeout.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (stimulus_done) begin
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial error_count = 0;

endmodule

>>> filelist.f
rtl/sss_pkg.sv
rtl/sss_if.sv
rtl/sss_div_pipe.sv
rtl/stereo_side_shaper.sv
rtl/sss_checker.sv
tb/sv/stereo_side_shaper_tb.sv
